// ----- rtl/ptc_pkg.sv -----
`default_nettype none
package ptc_pkg;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 64;
	localparam logic [CfgIdxW-1:0] REG_TEMP_CAL = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PCAL_LOW = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PCAL_HIGH = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_PCAL_LAST = 2'd3;
	localparam int DivSteps = 32;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} cal_t;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] fine;
		logic [31:0] num;
		logic [31:0] den;
		logic        hi;
		logic        valid;
	} div_req_t;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] fine;
		logic [31:0] quo;
		logic        valid;
	} div_rsp_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input int s);
		return 32'($signed(v) >>> s);
	endfunction
endpackage
`default_nettype wire

// ----- rtl/ptc_front.sv -----
`default_nettype none
module ptc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_v,
	input  wire logic [19:0]      adc_t,
	input  wire logic [19:0]      adc_p,
	input  wire ptc_pkg::cal_t    cal,
	output logic                  out_v,
	output ptc_pkg::div_req_t     req
);
	logic [31:0] t1, t2, t3;
	logic [31:0] x_c, d_c;
	assign t1 = {16'd0, cal.t1};
	assign t2 = ptc_pkg::sx16(cal.t2);
	assign t3 = ptc_pkg::sx16(cal.t3);
	assign x_c = {15'd0, adc_t[19:3]} - (t1 << 1);
	assign d_c = {16'd0, adc_t[19:4]} - t1;

	// s1: two products
	logic        v_s1;
	logic [31:0] a_s1, dd_s1;
	logic [19:0] p_s1;
	// s2
	logic        v_s2;
	logic [31:0] a_s2, b_s2;
	logic [19:0] p_s2;
	// s3: fine
	logic        v_s3;
	logic [31:0] fine_s3, af_s3;
	logic [19:0] p_s3;
	// s4
	logic        v_s4;
	logic [31:0] fine_s4, temp_s4, qq_s4, ap5_s4, ap2_s4;
	logic [19:0] p_s4;
	// s5
	logic        v_s5;
	logic [31:0] fine_s5, temp_s5, b6_s5, ap5_s5, c3_s5, ap2_s5;
	logic [19:0] p_s5;
	// s6
	logic        v_s6;
	logic [31:0] fine_s6, temp_s6, b_s6, x_s6;
	logic [19:0] p_s6;
	// s7
	logic        v_s7;
	logic [31:0] fine_s7, temp_s7, b_s7, den_s7;
	logic [19:0] p_s7;
	// s8
	logic        v_s8;
	logic [31:0] fine_s8, temp_s8, den_s8, num_s8;

	logic [31:0] q4, a3c, xa, bc, numc;
	assign q4 = ptc_pkg::asr(af_s3, 2);
	assign a3c = ptc_pkg::asr(ptc_pkg::asr(c3_s5, 3) + ptc_pkg::asr(ap2_s5, 1), 18);
	assign bc = ptc_pkg::asr(b6_s5 + (ap5_s5 << 1), 2) + (ptc_pkg::sx16(cal.p4) << 16);
	assign xa = 32'd32768 + x_s6;
	assign numc = ((32'd1048576 - {12'd0, p_s7}) - ptc_pkg::asr(b_s7, 12)) * 32'd3125;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{in_v, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= x_c * t2;
			dd_s1 <= d_c * d_c;
			p_s1 <= adc_p;
			a_s2 <= ptc_pkg::asr(a_s1, 11);
			b_s2 <= ptc_pkg::asr(dd_s1, 12) * t3;
			p_s2 <= p_s1;
			fine_s3 <= a_s2 + ptc_pkg::asr(b_s2, 14);
			af_s3 <= ptc_pkg::asr(a_s2 + ptc_pkg::asr(b_s2, 14), 1) - 32'd64000;
			p_s3 <= p_s2;
			fine_s4 <= fine_s3;
			temp_s4 <= ptc_pkg::asr(fine_s3 * 32'd5 + 32'd128, 8);
			qq_s4 <= q4 * q4;
			ap5_s4 <= af_s3 * ptc_pkg::sx16(cal.p5);
			ap2_s4 <= af_s3 * ptc_pkg::sx16(cal.p2);
			p_s4 <= p_s3;
			fine_s5 <= fine_s4;
			temp_s5 <= temp_s4;
			b6_s5 <= ptc_pkg::asr(qq_s4, 11) * ptc_pkg::sx16(cal.p6);
			ap5_s5 <= ap5_s4;
			c3_s5 <= ptc_pkg::sx16(cal.p3) * ptc_pkg::asr(qq_s4, 13);
			ap2_s5 <= ap2_s4;
			p_s5 <= p_s4;
			fine_s6 <= fine_s5;
			temp_s6 <= temp_s5;
			b_s6 <= bc;
			x_s6 <= a3c;
			p_s6 <= p_s5;
			fine_s7 <= fine_s6;
			temp_s7 <= temp_s6;
			b_s7 <= b_s6;
			den_s7 <= ptc_pkg::asr(xa * {16'd0, cal.p1}, 15);
			p_s7 <= p_s6;
			fine_s8 <= fine_s7;
			temp_s8 <= temp_s7;
			den_s8 <= den_s7;
			num_s8 <= numc;
		end
	end

	assign out_v = v_s8;
	always_comb begin
		req.temp = temp_s8;
		req.fine = fine_s8;
		req.den = den_s8;
		req.valid = den_s8 != 32'd0;
		req.hi = num_s8[31];
		req.num = num_s8[31] ? num_s8 : (num_s8 << 1);
	end
endmodule
`default_nettype wire

// ----- rtl/ptc_div.sv -----
`default_nettype none
module ptc_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_v,
	input  wire ptc_pkg::div_req_t req,
	output logic                out_v,
	output ptc_pkg::div_rsp_t   rsp
);
	// one restoring step per stage
	logic        v_q   [ptc_pkg::DivSteps];
	logic [31:0] rem_q [ptc_pkg::DivSteps];
	logic [31:0] num_q [ptc_pkg::DivSteps];
	logic [31:0] den_q [ptc_pkg::DivSteps];
	logic [31:0] tmp_q [ptc_pkg::DivSteps];
	logic [31:0] fin_q [ptc_pkg::DivSteps];
	logic        hi_q  [ptc_pkg::DivSteps];
	logic        ok_q  [ptc_pkg::DivSteps];

	for (genvar i = 0; i < ptc_pkg::DivSteps; i++) begin : g_step
		logic        v_i, hi_i, ok_i;
		logic [31:0] rem_i, num_i, den_i, tmp_i, fin_i;
		logic [32:0] r;
		logic [32:0] t;
		if (i == 0) begin : g_first
			assign v_i = in_v;
			assign rem_i = '0;
			assign num_i = req.num;
			assign den_i = req.den;
			assign tmp_i = req.temp;
			assign fin_i = req.fine;
			assign hi_i = req.hi;
			assign ok_i = req.valid;
		end else begin : g_next
			assign v_i = v_q[i-1];
			assign rem_i = rem_q[i-1];
			assign num_i = num_q[i-1];
			assign den_i = den_q[i-1];
			assign tmp_i = tmp_q[i-1];
			assign fin_i = fin_q[i-1];
			assign hi_i = hi_q[i-1];
			assign ok_i = ok_q[i-1];
		end
		assign r = {rem_i, num_i[31]};
		assign t = r - {1'b0, den_i};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i] <= 1'b0;
			else if (en) v_q[i] <= v_i;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= t[32] ? r[31:0] : t[31:0];
				num_q[i] <= {num_i[30:0], ~t[32]};
				den_q[i] <= den_i;
				tmp_q[i] <= tmp_i;
				fin_q[i] <= fin_i;
				hi_q[i] <= hi_i;
				ok_q[i] <= ok_i;
			end
		end
	end

	assign out_v = v_q[ptc_pkg::DivSteps-1];
	always_comb begin
		rsp.temp = tmp_q[ptc_pkg::DivSteps-1];
		rsp.fine = fin_q[ptc_pkg::DivSteps-1];
		rsp.valid = ok_q[ptc_pkg::DivSteps-1];
		rsp.quo = hi_q[ptc_pkg::DivSteps-1] ? (num_q[ptc_pkg::DivSteps-1] << 1)
			: num_q[ptc_pkg::DivSteps-1];
	end
endmodule
`default_nettype wire

// ----- rtl/ptc_back.sv -----
`default_nettype none
module ptc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_v,
	input  wire ptc_pkg::div_rsp_t rsp,
	input  wire ptc_pkg::cal_t  cal,
	output logic                out_v,
	output logic [31:0]         temp,
	output logic [31:0]         fine,
	output logic [31:0]         pres,
	output logic                ok
);
	logic [31:0] p, p3;
	assign p = rsp.valid ? rsp.quo : 32'd0;
	assign p3 = {3'd0, p[31:3]};

	logic        v_s1, v_s2, v_s3;
	logic [31:0] p_s1, sq_s1, b_s1, t_s1, f_s1;
	logic        ok_s1, ok_s2, ok_s3;
	logic [31:0] p_s2, a_s2, b_s2, t_s2, f_s2;
	logic [31:0] p_s3, t_s3, f_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) {v_s1, v_s2, v_s3} <= '0;
		else if (en) {v_s1, v_s2, v_s3} <= {in_v, v_s1, v_s2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p;
			sq_s1 <= (p3 * p3) >> 13;
			b_s1 <= ptc_pkg::asr({2'd0, p[31:2]} * ptc_pkg::sx16(cal.p8), 13);
			t_s1 <= rsp.temp;
			f_s1 <= rsp.fine;
			ok_s1 <= rsp.valid;
			p_s2 <= p_s1;
			a_s2 <= ptc_pkg::asr(ptc_pkg::sx16(cal.p9) * sq_s1, 12);
			b_s2 <= b_s1;
			t_s2 <= t_s1;
			f_s2 <= f_s1;
			ok_s2 <= ok_s1;
			p_s3 <= ok_s2 ? p_s2 + ptc_pkg::asr(a_s2 + b_s2 + ptc_pkg::sx16(cal.p7), 4)
				: 32'd0;
			t_s3 <= t_s2;
			f_s3 <= f_s2;
			ok_s3 <= ok_s2;
		end
	end

	assign out_v = v_s3;
	assign temp = t_s3;
	assign fine = f_s3;
	assign pres = p_s3;
	assign ok = ok_s3;
endmodule
`default_nettype wire

// ----- rtl/pressure_temperature_compensation.sv -----
// throughput: one word per cycle while the output is not stalled; the 32-step divider stage chain sets the depth
// a stall on the output freezes the whole pipeline, a skid register takes one
// more word and then input ready drops until the stall ends
// arst_n clears all valid bits and calibration registers to zero
`default_nettype none
module pressure_temperature_compensation (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [ptc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [ptc_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata, // raw_temperature, raw_pressure
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [95:0]       m_tdata, // temperature_centi, fine_temperature, pressure_pa
	output logic              m_tuser  // pressure_valid
);
	logic [47:0] tcal_q;
	logic [63:0] plo_q, phi_q;
	logic [15:0] plast_q;
	ptc_pkg::cal_t cal;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			plo_q <= '0;
			phi_q <= '0;
			plast_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptc_pkg::REG_TEMP_CAL:  tcal_q <= cfg_data[47:0];
				ptc_pkg::REG_PCAL_LOW:  plo_q <= cfg_data;
				ptc_pkg::REG_PCAL_HIGH: phi_q <= cfg_data;
				ptc_pkg::REG_PCAL_LAST: plast_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.t1 = tcal_q[15:0];
		cal.t2 = tcal_q[31:16];
		cal.t3 = tcal_q[47:32];
		cal.p1 = plo_q[15:0];
		cal.p2 = plo_q[31:16];
		cal.p3 = plo_q[47:32];
		cal.p4 = plo_q[63:48];
		cal.p5 = phi_q[15:0];
		cal.p6 = phi_q[31:16];
		cal.p7 = phi_q[47:32];
		cal.p8 = phi_q[63:48];
		cal.p9 = plast_q;
	end

	// input skid
	logic        sk_v_q;
	logic [39:0] sk_d_q;
	logic        en, pv;
	logic [39:0] pd;
	assign s_tready = !sk_v_q;
	assign pv = sk_v_q | s_tvalid;
	assign pd = sk_v_q ? sk_d_q : s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sk_v_q <= 1'b0;
		else if (en) sk_v_q <= 1'b0;
		else if (s_tvalid && s_tready) sk_v_q <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready && !en) sk_d_q <= s_tdata;
	end

	logic f_v, d_v, b_v;
	ptc_pkg::div_req_t req;
	ptc_pkg::div_rsp_t rsp;
	logic [31:0] o_t, o_f, o_p;
	logic o_ok;

	assign en = !m_tvalid || m_tready;

	ptc_front u_front (.clk, .arst_n, .en, .in_v(pv), .adc_t(pd[19:0]),
		.adc_p(pd[39:20]), .cal, .out_v(f_v), .req);
	ptc_div u_div (.clk, .arst_n, .en, .in_v(f_v), .req, .out_v(d_v), .rsp);
	ptc_back u_back (.clk, .arst_n, .en, .in_v(d_v), .rsp, .cal, .out_v(b_v),
		.temp(o_t), .fine(o_f), .pres(o_p), .ok(o_ok));

	assign m_tvalid = b_v;
	assign m_tdata = {o_p, o_f, o_t};
	assign m_tuser = o_ok;
endmodule
`default_nettype wire

// ----- rtl/ptc_checker.sv -----
`default_nettype none
module ptc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [95:0] m_tdata,
	input wire logic        m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word dropped");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[95:64] == 32'd0)
		else $error("invalid pressure not zero");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tready || m_tvalid)
		else $error("input stuck with idle output");
endmodule
bind pressure_temperature_compensation ptc_checker u_chk (.clk, .arst_n, .s_tvalid,
	.s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser);
`default_nettype wire
